// ----- rtl/core/sic_pkg.sv -----
// Shared types and constants for the scaled icon compositor.
package sic_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_BACKING = 2'd0,
    CMD_LOAD_ICON    = 2'd1,
    CMD_COMPOSE      = 2'd2,
    CMD_READ         = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_BACKING_W = 3'd0,
    REG_BACKING_H = 3'd1,
    REG_ICON_W    = 3'd2,
    REG_ICON_H    = 3'd3,
    REG_OUTPUT_W  = 3'd4,
    REG_OUTPUT_H  = 3'd5,
    REG_BOX_W     = 3'd6,
    REG_BOX_H     = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_DIV,
    S_P1_ROW,
    S_P1_ROWQ,
    S_P1_COL,
    S_P1_COLQ,
    S_P1_RD,
    S_P1_WR,
    S_P2_ROW,
    S_P2_ROWQ,
    S_P2_COL,
    S_P2_COLQ,
    S_P2_RD,
    S_P2_BL,
    S_P2_WR,
    S_DONE
  } state_e;

  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_COMPOSE = 1'b1;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;
  localparam int unsigned ALPHA_LSB = 24;
  localparam int unsigned DIV_STEPS = 16;

  // source store depth; a power of two so the address wrap is a mask
  localparam int unsigned SOURCE_DEPTH = 4096;

endpackage

// ----- rtl/core/scaled_icon_composite.sv -----
// Scaled icon compositor: image stores, compose sequencer and read port.
//
// Input channel (in_valid_i / in_stall_o) carries one command item:
//   load backing pixel, load icon pixel, compose, or read output pixel.
// Loads give no result. A read gives a kind 0 item with the stored pixel,
// read from the output store into a register and then into the output
// register. A compose gives a kind 1 item when done; a shared restoring
// divider does every row and column scale. A compose first scales the
// backing into every output pixel, then walks the box rows and columns,
// skips the clipped ones and blends each visible icon pixel over the output.
// Input is stalled while a command is at work and while an unread result
// sits in the output register with out_stall_i high.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes one size register
// per cycle and is always ready; write it only while the block is idle.
// Reset clears control state and sets every size register to 1; the image
// stores are undefined until written.
module scaled_icon_composite #(
  parameter int unsigned MAX_OUT_W    = 64,
  parameter int unsigned MAX_OUT_H    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sic_pkg::cmd_e      cmd_i,
  input  logic [11:0]        pixel_index_i,
  input  logic [31:0]        pixel_value_i,
  input  logic signed [7:0]  box_left_i,
  input  logic signed [7:0]  box_top_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [31:0]        read_pixel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  import sic_pkg::*;

  localparam int unsigned OutDepth = MAX_OUT_W * MAX_OUT_H;
  localparam int unsigned OAW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned SAW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;

  // size registers
  logic [6:0] bw_q, bh_q, iw_q, ih_q, ow_q, oh_q, xw_q, xh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= 7'd1; bh_q <= 7'd1; iw_q <= 7'd1; ih_q <= 7'd1;
      ow_q <= 7'd1; oh_q <= 7'd1; xw_q <= 7'd1; xh_q <= 7'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_BACKING_W: bw_q <= cfg_data_i;
        REG_BACKING_H: bh_q <= cfg_data_i;
        REG_ICON_W:    iw_q <= cfg_data_i;
        REG_ICON_H:    ih_q <= cfg_data_i;
        REG_OUTPUT_W:  ow_q <= cfg_data_i;
        REG_OUTPUT_H:  oh_q <= cfg_data_i;
        REG_BOX_W:     xw_q <= cfg_data_i;
        REG_BOX_H:     xh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // effective sizes: zero reads as one, output clamped to the store
  logic [6:0] bw, bh, iw, ih, xw, xh, ow1, oh1;
  logic [8:0] ow, oh;

  assign bw  = (bw_q == 7'd0) ? 7'd1 : bw_q;
  assign bh  = (bh_q == 7'd0) ? 7'd1 : bh_q;
  assign iw  = (iw_q == 7'd0) ? 7'd1 : iw_q;
  assign ih  = (ih_q == 7'd0) ? 7'd1 : ih_q;
  assign xw  = (xw_q == 7'd0) ? 7'd1 : xw_q;
  assign xh  = (xh_q == 7'd0) ? 7'd1 : xh_q;
  assign ow1 = (ow_q == 7'd0) ? 7'd1 : ow_q;
  assign oh1 = (oh_q == 7'd0) ? 7'd1 : oh_q;
  assign ow  = (32'(ow1) > MAX_OUT_W) ? 9'(MAX_OUT_W) : 9'(ow1);
  assign oh  = (32'(oh1) > MAX_OUT_H) ? 9'(MAX_OUT_H) : 9'(oh1);

  // sequencer and datapath registers
  state_e state_q, state_d, ret_q, ret_d;
  logic [8:0]  r_q, r_d, c_q, c_d;
  logic [6:0]  sr_q, sr_d;
  logic [7:0]  left_q, left_d, top_q, top_d;
  logic [15:0] num_q, num_d, quo_q, quo_d;
  logic [16:0] den_q, den_d, rem_q, rem_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  ch_q, ch_d;
  logic [31:0] res_q, res_d;
  logic        rd_ok_q, rd_ok_d;
  logic        out_valid_q, out_valid_d, kind_q, kind_d;
  logic [31:0] read_q, read_d;

  logic [31:0] bk_rd_q, ic_rd_q, op_rd_q;

  logic accept;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // geometry
  logic signed [9:0] tr, tc;
  logic              row_done, col_done, tr_bad, tc_bad;
  logic [16:0]       idx_ext, out_limit;
  logic [17:0]       p1_pos, p2_pos;
  logic [15:0]       src_lin;

  assign tr = 10'(signed'(top_q)) + signed'({1'b0, r_q});
  assign tc = 10'(signed'(left_q)) + signed'({1'b0, c_q});
  assign tr_bad = (tr < 0) || (tr >= signed'({1'b0, oh}));
  assign tc_bad = (tc < 0) || (tc >= signed'({1'b0, ow}));
  assign p1_pos = r_q * ow + 18'(c_q);
  assign p2_pos = tr[8:0] * ow + 18'(tc[8:0]);
  assign idx_ext = 17'(pixel_index_i);
  assign out_limit = 17'(OutDepth - 1);

  always_comb begin
    row_done = 1'b0;
    col_done = 1'b0;
    src_lin  = '0;
    unique case (state_q)
      S_P1_ROW:  row_done = (r_q == oh);
      S_P1_COL:  col_done = (c_q == ow);
      S_P1_COLQ: src_lin  = 16'(sr_q * bw) + 16'(quo_q[6:0]);
      S_P2_ROW:  row_done = (r_q == 9'(xh));
      S_P2_COL:  col_done = (c_q == 9'(xw));
      S_P2_COLQ: src_lin  = 16'(sr_q * iw) + 16'(quo_q[6:0]);
      default: ;
    endcase
  end

  // divider step
  logic [17:0] div_sh;
  logic        div_ge;
  assign div_sh = {rem_q, num_q[15]};
  assign div_ge = div_sh >= {1'b0, den_q};

  // blend of one channel; x/255 = (x + 1 + (x >> 8)) >> 8 for x up to 255 * 255
  logic [7:0]  alpha, inv, sb, db, bl_byte;
  logic [16:0] bl_sum, bl_q8;
  assign alpha  = ic_rd_q[31:ALPHA_LSB];
  assign inv    = ALPHA_FULL - alpha;
  assign sb     = (ch_q == 2'd3) ? ALPHA_FULL : ic_rd_q[ch_q*8 +: 8];
  assign db     = op_rd_q[ch_q*8 +: 8];
  assign bl_sum = 17'(sb * alpha) + 17'(db * inv);
  assign bl_q8  = bl_sum + 17'd1 + 17'(bl_sum[16:8]);
  assign bl_byte = bl_q8[15:8];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_COMPOSE: state_d = S_P1_ROW;
            CMD_READ:    state_d = S_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_RD:      state_d = S_IDLE;
      S_DIV:     if (cnt_q == 4'(DIV_STEPS - 1)) state_d = ret_q;
      S_P1_ROW:  state_d = row_done ? S_P2_ROW : S_DIV;
      S_P1_ROWQ: state_d = S_P1_COL;
      S_P1_COL:  state_d = col_done ? S_P1_ROW : S_DIV;
      S_P1_COLQ: state_d = S_P1_RD;
      S_P1_RD:   state_d = S_P1_WR;
      S_P1_WR:   state_d = S_P1_COL;
      S_P2_ROW: begin
        if (row_done)    state_d = S_DONE;
        else if (!tr_bad) state_d = S_DIV;
      end
      S_P2_ROWQ: state_d = S_P2_COL;
      S_P2_COL: begin
        if (col_done)    state_d = S_P2_ROW;
        else if (!tc_bad) state_d = S_DIV;
      end
      S_P2_COLQ: state_d = S_P2_RD;
      S_P2_RD:   state_d = S_P2_BL;
      S_P2_BL:   if (ch_q == 2'd3) state_d = S_P2_WR;
      S_P2_WR:   state_d = S_P2_COL;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ret_d = ret_q;  r_d = r_q;  c_d = c_q;  sr_d = sr_q;
    left_d = left_q;  top_d = top_q;
    num_d = num_q;  den_d = den_q;  quo_d = quo_q;  rem_d = rem_q;  cnt_d = cnt_q;
    ch_d = ch_q;  res_d = res_q;  rd_ok_d = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d = kind_q;  read_d = read_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          left_d  = box_left_i;
          top_d   = box_top_i;
          r_d     = '0;
          rd_ok_d = (idx_ext <= out_limit);
        end
      end
      S_RD: begin
        out_valid_d = 1'b1;
        kind_d      = KIND_READ;
        read_d      = rd_ok_q ? op_rd_q : '0;
      end
      S_DIV: begin
        num_d = {num_q[14:0], 1'b0};
        quo_d = {quo_q[14:0], div_ge};
        rem_d = div_ge ? 17'(div_sh - {1'b0, den_q}) : div_sh[16:0];
        cnt_d = cnt_q + 4'd1;
      end
      S_P1_ROW: begin
        if (row_done) begin
          r_d = '0;
        end else begin
          num_d = 16'(r_q * bh);  den_d = 17'(oh);
          rem_d = '0;  cnt_d = '0;  ret_d = S_P1_ROWQ;
        end
      end
      S_P1_ROWQ: begin
        sr_d = quo_q[6:0];
        c_d  = '0;
      end
      S_P1_COL: begin
        if (col_done) begin
          r_d = r_q + 9'd1;
        end else begin
          num_d = 16'(c_q * bw);  den_d = 17'(ow);
          rem_d = '0;  cnt_d = '0;  ret_d = S_P1_COLQ;
        end
      end
      S_P1_COLQ, S_P2_COLQ: begin
        // source address wraps at the store depth
        rem_d = 17'(src_lin[SAW-1:0]);
      end
      S_P1_WR: c_d = c_q + 9'd1;
      S_P2_ROW: begin
        if (!row_done) begin
          if (tr_bad) begin
            r_d = r_q + 9'd1;
          end else begin
            num_d = 16'(r_q * ih);  den_d = 17'(xh);
            rem_d = '0;  cnt_d = '0;  ret_d = S_P2_ROWQ;
          end
        end
      end
      S_P2_ROWQ: begin
        sr_d = quo_q[6:0];
        c_d  = '0;
      end
      S_P2_COL: begin
        if (col_done) begin
          r_d = r_q + 9'd1;
        end else if (tc_bad) begin
          c_d = c_q + 9'd1;
        end else begin
          num_d = 16'(c_q * iw);  den_d = 17'(xw);
          rem_d = '0;  cnt_d = '0;  ret_d = S_P2_COLQ;
        end
      end
      S_P2_RD: ch_d = '0;
      S_P2_BL: begin
        res_d[ch_q*8 +: 8] = bl_byte;
        ch_d = ch_q + 2'd1;
      end
      S_P2_WR: c_d = c_q + 9'd1;
      S_DONE: begin
        out_valid_d = 1'b1;
        kind_d      = KIND_COMPOSE;
        read_d      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      r_q         <= r_d;
      c_q         <= c_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q    <= sr_d;
    left_q  <= left_d;
    top_q   <= top_d;
    num_q   <= num_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    rd_ok_q <= rd_ok_d;
    kind_q  <= kind_d;
    read_q  <= read_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign read_pixel_o = read_q;

  // image stores
  logic [31:0] bk_mem [SOURCE_DEPTH];
  logic [31:0] ic_mem [SOURCE_DEPTH];
  logic [31:0] op_mem [OutDepth];

  logic           ld_ok, bk_we, ic_we, op_we;
  logic [SAW-1:0] ld_addr, src_addr;
  logic [OAW-1:0] op_raddr, op_waddr;
  logic [31:0]    op_wdata;

  assign ld_ok    = idx_ext < 17'(SOURCE_DEPTH);
  assign ld_addr  = idx_ext[SAW-1:0];
  assign src_addr = rem_q[SAW-1:0];
  assign bk_we    = accept && (cmd_i == CMD_LOAD_BACKING) && ld_ok;
  assign ic_we    = accept && (cmd_i == CMD_LOAD_ICON) && ld_ok;
  assign op_raddr = (state_q == S_IDLE) ? idx_ext[OAW-1:0] : p2_pos[OAW-1:0];
  assign op_we    = (state_q == S_P1_WR) || (state_q == S_P2_WR);
  assign op_waddr = (state_q == S_P1_WR) ? p1_pos[OAW-1:0] : p2_pos[OAW-1:0];

  always_comb begin
    if (state_q == S_P1_WR)       op_wdata = bk_rd_q;
    else if (alpha == ALPHA_FULL) op_wdata = ic_rd_q;
    else if (alpha == 8'd0)       op_wdata = op_rd_q;
    else                          op_wdata = res_q;
  end

  always_ff @(posedge clk_i) begin
    if (bk_we) bk_mem[ld_addr] <= pixel_value_i;
    bk_rd_q <= bk_mem[src_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ic_we) ic_mem[ld_addr] <= pixel_value_i;
    ic_rd_q <= ic_mem[src_addr];
  end

  always_ff @(posedge clk_i) begin
    if (op_we) op_mem[op_waddr] <= op_wdata;
    op_rd_q <= op_mem[op_raddr];
  end

endmodule

// ----- test/sic_checker.sv -----
// Channel monitor, image compositor predictor and result comparison.
`timescale 1ns / 1ps

module sic_checker
  import sic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  cmd_e               cmd_i,
  input  logic [11:0]        pixel_index_i,
  input  logic [31:0]        pixel_value_i,
  input  logic signed [7:0]  box_left_i,
  input  logic signed [7:0]  box_top_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               kind_i,
  input  logic [31:0]        read_pixel_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  localparam int unsigned MAX_W = 64;
  localparam int unsigned MAX_H = 64;
  localparam int unsigned DEPTH = 4096;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel;
  } pixel_item_t;

  logic [31:0] backing_mem [DEPTH];
  logic [31:0] icon_mem    [DEPTH];
  logic [31:0] canvas      [MAX_W * MAX_H];
  logic [6:0]  size_reg    [8];
  pixel_item_t awaited_q   [$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  function automatic int unsigned fit_dim(logic [6:0] v);
    return (v == 7'd0) ? 1 : int'(v);
  endfunction

  function automatic int unsigned clamp_dim(logic [6:0] v, int unsigned hi);
    int unsigned d;
    d = fit_dim(v);
    return (d > hi) ? hi : d;
  endfunction

  function automatic logic [31:0] blend_over(logic [31:0] dst, logic [31:0] src);
    int unsigned a, inv, oa, r, g, b;
    a   = src[31:24];
    inv = 255 - a;
    if (a == 255) return src;
    if (a == 0) return dst;
    oa = a + (dst[31:24] * inv) / 255;
    r  = (src[23:16] * a + dst[23:16] * inv) / 255;
    g  = (src[15:8] * a + dst[15:8] * inv) / 255;
    b  = (src[7:0] * a + dst[7:0] * inv) / 255;
    return {oa[7:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic void paint_canvas(int left, int top);
    int unsigned bw, bh, iw, ih, ow, oh, xw, xh, sr, sc, pos, r, c;
    int tr, tc;
    bw = fit_dim(size_reg[REG_BACKING_W]);
    bh = fit_dim(size_reg[REG_BACKING_H]);
    iw = fit_dim(size_reg[REG_ICON_W]);
    ih = fit_dim(size_reg[REG_ICON_H]);
    ow = clamp_dim(size_reg[REG_OUTPUT_W], MAX_W);
    oh = clamp_dim(size_reg[REG_OUTPUT_H], MAX_H);
    xw = fit_dim(size_reg[REG_BOX_W]);
    xh = fit_dim(size_reg[REG_BOX_H]);
    for (r = 0; r < oh; r++) begin
      sr = r * bh / oh;
      for (c = 0; c < ow; c++) begin
        sc = c * bw / ow;
        canvas[r * ow + c] = backing_mem[(sr * bw + sc) % DEPTH];
      end
    end
    for (r = 0; r < xh; r++) begin
      tr = top + int'(r);
      sr = r * ih / xh;
      if (tr < 0 || tr >= int'(oh)) continue;
      for (c = 0; c < xw; c++) begin
        tc = left + int'(c);
        sc = c * iw / xw;
        if (tc < 0 || tc >= int'(ow)) continue;
        pos = tr * ow + tc;
        canvas[pos] = blend_over(canvas[pos], icon_mem[(sr * iw + sc) % DEPTH]);
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) size_reg[i] = 7'd1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) size_reg[cfg_index_i] = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected item", 32'h0, read_pixel_i);
        end else begin
          want = awaited_q.pop_front();
          if (kind_i !== want.kind) report_mismatch("kind", want.kind, kind_i);
          if (read_pixel_i !== want.pixel) report_mismatch("read_pixel", want.pixel,
                                                           read_pixel_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          CMD_LOAD_BACKING: backing_mem[pixel_index_i] = pixel_value_i;
          CMD_LOAD_ICON:    icon_mem[pixel_index_i] = pixel_value_i;
          CMD_COMPOSE: begin
            paint_canvas(box_left_i, box_top_i);
            awaited_q.push_back('{kind: KIND_COMPOSE, pixel: 32'h0});
          end
          default: begin
            // index is 12 bits, so it never passes the canvas depth
            awaited_q.push_back('{kind: KIND_READ, pixel: canvas[pixel_index_i]});
          end
        endcase
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// Stimulus and verdict for the scaled icon compositor.
`timescale 1ns / 1ps

module tb;
  import sic_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned ITEMS       = 1150;

  logic              clk_i, rst_ni;
  logic              in_valid, in_stall, out_valid, out_stall, kind;
  cmd_e              cmd;
  logic [11:0]       pix_idx;
  logic [31:0]       pix_val, read_pixel;
  logic signed [7:0] box_left, box_top;
  logic              cfg_valid, cfg_ready;
  logic [2:0]        cfg_index;
  logic [6:0]        cfg_data;
  int unsigned       pending, errors, cycles;
  int unsigned       sent, base;
  bit                quiet;

  // mirror of what has been written, so no never-written entry is used
  logic [6:0]  reg_mirror [8];
  bit          backing_loaded [DEPTH];
  bit          icon_loaded [DEPTH];
  int unsigned canvas_span;

  scaled_icon_composite DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .pixel_index_i(pix_idx), .pixel_value_i(pix_val),
    .box_left_i(box_left), .box_top_i(box_top),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .read_pixel_o(read_pixel),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  sic_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .pixel_index_i(pix_idx), .pixel_value_i(pix_val),
    .box_left_i(box_left), .box_top_i(box_top),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .kind_i(kind), .read_pixel_i(read_pixel),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk_i) cycles++;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (hold == 0) begin
        out_stall = ($urandom_range(0, 2) == 0);
        hold = $urandom_range(1, 16);
      end else begin
        hold--;
      end
    end
  end

  function automatic int unsigned dim_of(logic [6:0] v);
    return (v == 7'd0) ? 1 : int'(v);
  endfunction

  function automatic logic [31:0] rand_argb();
    logic [7:0] a;
    case ($urandom_range(0, 3))
      0: a = 8'h00;
      1: a = ALPHA_FULL;
      default: a = $urandom_range(0, 255);
    endcase
    return {a, 24'($urandom())};
  endfunction

  task automatic send_item(cmd_e c, logic [11:0] i, logic [31:0] v,
                           logic [7:0] l, logic [7:0] t);
    cmd = c; pix_idx = i; pix_val = v; box_left = l; box_top = t;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
    sent++;
    if (c == CMD_LOAD_BACKING) backing_loaded[i] = 1'b1;
    if (c == CMD_LOAD_ICON) icon_loaded[i] = 1'b1;
    if (!quiet && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [6:0] v);
    cfg_index = r; cfg_data = v; cfg_valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    reg_mirror[r] = v;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // loads every source entry the next compose reads that is not loaded yet
  task automatic compose_at(logic [7:0] l, logic [7:0] t);
    int unsigned bw, bh, iw, ih, ow, oh, xw, xh, sr, a;
    int tr, tc;
    bw = dim_of(reg_mirror[REG_BACKING_W]);
    bh = dim_of(reg_mirror[REG_BACKING_H]);
    iw = dim_of(reg_mirror[REG_ICON_W]);
    ih = dim_of(reg_mirror[REG_ICON_H]);
    ow = dim_of(reg_mirror[REG_OUTPUT_W]);
    oh = dim_of(reg_mirror[REG_OUTPUT_H]);
    xw = dim_of(reg_mirror[REG_BOX_W]);
    xh = dim_of(reg_mirror[REG_BOX_H]);
    if (ow > 64) ow = 64;
    if (oh > 64) oh = 64;
    for (int unsigned r = 0; r < oh; r++) begin
      sr = r * bh / oh;
      for (int unsigned c = 0; c < ow; c++) begin
        a = (sr * bw + c * bw / ow) % DEPTH;
        if (!backing_loaded[a]) send_item(CMD_LOAD_BACKING, 12'(a), rand_argb(), 0, 0);
      end
    end
    for (int unsigned r = 0; r < xh; r++) begin
      tr = int'(signed'(t)) + int'(r);
      if (tr < 0 || tr >= int'(oh)) continue;
      sr = r * ih / xh;
      for (int unsigned c = 0; c < xw; c++) begin
        tc = int'(signed'(l)) + int'(c);
        if (tc < 0 || tc >= int'(ow)) continue;
        a = (sr * iw + c * iw / xw) % DEPTH;
        if (!icon_loaded[a]) send_item(CMD_LOAD_ICON, 12'(a), rand_argb(), 0, 0);
      end
    end
    send_item(CMD_COMPOSE, $urandom(), $urandom(), l, t);
    if (ow * oh > canvas_span) canvas_span = ow * oh;
  endtask

  task automatic read_any();
    if (canvas_span != 0)
      send_item(CMD_READ, $urandom_range(0, canvas_span - 1), $urandom(),
                $urandom(), $urandom());
  endtask

  // runs random items until the item count reaches the target
  task automatic random_phase(int unsigned target);
    logic [6:0] v;
    int unsigned ow, oh;
    wait_drained();
    for (int r = 0; r < 8; r++) begin
      if (r == REG_OUTPUT_W || r == REG_OUTPUT_H) v = $urandom_range(0, 12);
      else if ($urandom_range(0, 7) == 0) v = $urandom_range(64, 127);
      else v = $urandom_range(0, 12);
      write_reg(reg_e'(r), v);
    end
    ow = dim_of(reg_mirror[REG_OUTPUT_W]);
    oh = dim_of(reg_mirror[REG_OUTPUT_H]);
    while (sent < target) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          // mostly boxes that land on the canvas, sometimes anywhere
          if ($urandom_range(0, 3) == 0) compose_at($urandom(), $urandom());
          else compose_at($urandom_range(0, ow + 2) - 3, $urandom_range(0, oh + 2) - 3);
        end
        2, 3, 4, 5:    send_item(CMD_LOAD_BACKING, $urandom(), rand_argb(), 0, 0);
        6, 7, 8, 9:    send_item(CMD_LOAD_ICON, $urandom(), rand_argb(), 0, 0);
        default: read_any();
      endcase
    end
  endtask

  initial begin
    quiet = 1'b0;
    canvas_span = 0;
    sent = 0;
    in_valid = 1'b0; cmd = CMD_LOAD_BACKING; pix_idx = '0; pix_val = '0;
    box_left = '0; box_top = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    for (int r = 0; r < 8; r++) reg_mirror[r] = 7'd1;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every size register at zero acts as one
    for (int r = 0; r < 8; r++) write_reg(reg_e'(r), 7'd0);
    send_item(CMD_LOAD_BACKING, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_LOAD_ICON, 0, 32'h0012_3456, 0, 0);
    compose_at(0, 0);
    send_item(CMD_READ, 0, 0, 0, 0);
    send_item(CMD_LOAD_ICON, 0, 32'hFFAB_CDEF, 0, 0);
    compose_at(0, 0);
    send_item(CMD_READ, 0, 0, 0, 0);
    send_item(CMD_LOAD_ICON, 0, 32'h80FF_0080, 0, 0);
    compose_at(0, 0);
    send_item(CMD_READ, 0, 0, 0, 0);
    send_item(CMD_LOAD_BACKING, 0, 32'h0000_0000, 0, 0);
    compose_at(8'h80, 8'h80);
    send_item(CMD_READ, 0, 0, 0, 0);
    compose_at(8'h7F, 8'h7F);
    send_item(CMD_READ, 0, 0, 0, 0);
    send_item(CMD_LOAD_BACKING, 12'hFFF, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_LOAD_ICON, 12'hFFF, 32'h0000_0000, 0, 0);

    // largest output and a box of the same size; output beyond the limit saturates
    wait_drained();
    write_reg(REG_BACKING_W, 7'd64);
    write_reg(REG_BACKING_H, 7'd2);
    write_reg(REG_ICON_W, 7'd64);
    write_reg(REG_ICON_H, 7'd2);
    write_reg(REG_OUTPUT_W, 7'd127);
    write_reg(REG_OUTPUT_H, 7'd127);
    write_reg(REG_BOX_W, 7'd64);
    write_reg(REG_BOX_H, 7'd64);
    compose_at(-8, -8);
    send_item(CMD_READ, 12'hFFF, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0, 0);
    for (int n = 0; n < 30; n++) read_any();

    // source addresses that wrap past the store
    wait_drained();
    write_reg(REG_BACKING_W, 7'd127);
    write_reg(REG_BACKING_H, 7'd100);
    write_reg(REG_ICON_W, 7'd90);
    write_reg(REG_ICON_H, 7'd127);
    write_reg(REG_OUTPUT_W, 7'd9);
    write_reg(REG_OUTPUT_H, 7'd7);
    write_reg(REG_BOX_W, 7'd127);
    write_reg(REG_BOX_H, 7'd5);
    compose_at(-3, 2);
    for (int n = 0; n < 10; n++) read_any();

    base = sent;
    for (int p = 1; p < 10; p++) random_phase(base + (ITEMS - base) * p / 10);
    quiet = 1'b1;
    random_phase(sent + (ITEMS - base) / 10);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
